[rtl/core/htfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types and constants for the humidity/temperature frame decoder:
// frame kinds, field widths, CRC-8 column masks and the fixed-point
// conversion constants.
// ----------------------------------------------------------------------------
package htfd_pkg;

  typedef enum logic {
    KIND_TEMP = 1'b0,
    KIND_HUM  = 1'b1
  } kind_t;

  localparam int TEMP_W = 15;
  localparam int HUM_W  = 14;

  localparam logic [7:0] STATUS_MASK = 8'hFC;

  // Temperature: -4685 + (17572 * raw) >> 16, in 0.01 C.
  localparam int TEMP_SCALE  = 17572;
  localparam int TEMP_OFFSET = -4685;

  // Humidity: -600 + (12500 * raw) >> 16 + ((T - 2500) * 9830) >> 16, in 0.01 %.
  localparam int HUM_SCALE  = 12500;
  localparam int HUM_OFFSET = -600;
  localparam int COMP_REF   = 2500;
  localparam int COMP_SCALE = 9830;
  localparam int HUM_MAX    = 10000;

  // CRC-8 (poly 0x31, init 0) over a 16-bit word is linear in the data bits.
  // Entry i is the remainder contributed by data bit i, i.e. x^(i+8) mod P.
  localparam logic [7:0] CRC_COLUMN [16] = '{
    8'h31, 8'h62, 8'hC4, 8'hB9, 8'h43, 8'h86, 8'h3D, 8'h7A,
    8'hF4, 8'hD9, 8'h83, 8'h37, 8'h6E, 8'hDC, 8'h89, 8'h23
  };

  typedef struct packed {
    kind_t                     frame_kind;
    logic                      crc_ok;
    logic signed [TEMP_W-1:0]  temperature_centi;
    logic        [HUM_W-1:0]   humidity_centi;
  } htfd_result_t;

endpackage
`default_nettype wire

[rtl/core/humidity_temp_frame_decoder_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_core
// Decodes three-byte sensor frames into temperature and compensated humidity
// in hundredths, with CRC-8 check and remembered temperature.
//
//   Channel  Dir  Width            Contents
//   s_*      in   tdata 24, user 1 tdata: msb_byte, lsb_byte, crc_byte; tuser: kind
//   m_*      out  tdata 32, user 1 tdata: crc_ok, temperature, humidity; tuser: kind
//
// One frame per cycle sustained while m_tready is high; an accepted request
// passes through the input register and then the result register before it
// shows as a valid result.
// The stored temperature updates as a temperature frame enters the result
// register, so the next humidity frame already sees it.
// Synchronous reset clears both valid flags and the stored temperature to 0.
// A stall on m_tready holds both stages; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_core
  import htfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [7:0] msb_byte, [15:8] lsb_byte, [23:16] crc_byte
  input  wire logic        s_tuser,   // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [0] crc_ok, [15:1] temperature_centi,
                                      // [29:16] humidity_centi, [31:30] zero
  output logic             m_tuser    // [0] frame_kind
);

  logic        in_valid;
  kind_t       in_kind;
  logic [7:0]  in_msb;
  logic [7:0]  in_lsb;
  logic [7:0]  in_crc;

  logic                     out_valid;
  htfd_result_t             out_result;
  logic signed [TEMP_W-1:0] last_temperature;

  logic         advance;
  logic         s_accept;
  logic         crc_ok;
  htfd_result_t result_next;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  htfd_crc8 u_crc (
    .msb_byte (in_msb),
    .lsb_byte (in_lsb),
    .crc_byte (in_crc),
    .crc_ok   (crc_ok)
  );

  htfd_convert u_convert (
    .kind             (in_kind),
    .msb_byte         (in_msb),
    .lsb_byte         (in_lsb),
    .crc_ok           (crc_ok),
    .last_temperature (last_temperature),
    .result           (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      out_valid        <= 1'b0;
      last_temperature <= '0;
    end else begin
      if (s_accept) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (advance && in_valid && in_kind == KIND_TEMP) begin
        last_temperature <= result_next.temperature_centi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_kind <= kind_t'(s_tuser);
      in_msb  <= s_tdata[7:0];
      in_lsb  <= s_tdata[15:8];
      in_crc  <= s_tdata[23:16];
    end
    if (advance && in_valid) begin
      out_result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_result.frame_kind;
  assign m_tdata  = {2'b00, out_result.humidity_centi,
                     out_result.temperature_centi, out_result.crc_ok};

  a_temp_no_hum: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_result.frame_kind == KIND_TEMP) |-> out_result.humidity_centi == '0)
    else $error("temperature request produced a humidity value");

  a_bad_crc_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_result.crc_ok) |->
      (out_result.humidity_centi == '0 && out_result.temperature_centi == '0))
    else $error("bad CRC request produced a nonzero value");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_result.humidity_centi <= HUM_W'(HUM_MAX))
    else $error("humidity above clamp limit");

  a_temp_stored: assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid && in_kind == KIND_TEMP) |=>
      last_temperature == out_result.temperature_centi)
    else $error("stored temperature differs from delivered temperature");

endmodule
`default_nettype wire

[rtl/core/htfd_crc8.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_crc8
// Checks the received CRC byte against a CRC-8 computed over the high and
// low data bytes, as a parallel XOR of per-bit column masks.
// ----------------------------------------------------------------------------
module htfd_crc8
  import htfd_pkg::*;
(
  input  wire logic [7:0] msb_byte,
  input  wire logic [7:0] lsb_byte,
  input  wire logic [7:0] crc_byte,
  output logic            crc_ok
);

  logic [15:0] data_word;
  logic [7:0]  crc_calc;

  assign data_word = {msb_byte, lsb_byte};

  always_comb begin
    crc_calc = 8'h00;
    for (int i = 0; i < 16; i++) begin
      if (data_word[i]) begin
        crc_calc = crc_calc ^ CRC_COLUMN[i];
      end
    end
  end

  assign crc_ok = (crc_calc == crc_byte);

endmodule
`default_nettype wire

[rtl/core/htfd_convert.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_convert
// Converts the masked raw reading into temperature or compensated humidity
// in hundredths, zeroing the field that does not apply or a bad-CRC value.
// ----------------------------------------------------------------------------
module htfd_convert
  import htfd_pkg::*;
(
  input  wire kind_t               kind,
  input  wire logic [7:0]          msb_byte,
  input  wire logic [7:0]          lsb_byte,
  input  wire logic                crc_ok,
  input  wire logic signed [TEMP_W-1:0] last_temperature,
  output htfd_result_t             result
);

  logic [15:0]        raw;
  logic [30:0]        t_prod;
  logic signed [15:0] temp_full;
  logic [29:0]        h_prod;
  logic signed [15:0] comp_diff;
  logic signed [31:0] comp_prod;
  logic signed [17:0] hum_sum;
  logic [HUM_W-1:0]   hum_clamped;

  assign raw = {msb_byte, lsb_byte & STATUS_MASK};

  assign t_prod    = 31'(raw) * 31'(TEMP_SCALE);
  assign temp_full = $signed({1'b0, t_prod[30:16]}) + $signed(16'(TEMP_OFFSET));

  assign h_prod    = 30'(raw) * 30'(HUM_SCALE);
  assign comp_diff = $signed({last_temperature[TEMP_W-1], last_temperature})
                     - $signed(16'(COMP_REF));
  assign comp_prod = $signed({{16{comp_diff[15]}}, comp_diff}) * $signed(32'(COMP_SCALE));

  // Upper half of a two's complement product is the floor of the division.
  assign hum_sum = $signed({4'b0000, h_prod[29:16]})
                 + $signed(18'(HUM_OFFSET))
                 + $signed({{2{comp_prod[31]}}, comp_prod[31:16]});

  always_comb begin
    if (hum_sum < 0) begin
      hum_clamped = '0;
    end else if (hum_sum > $signed(18'(HUM_MAX))) begin
      hum_clamped = HUM_W'(HUM_MAX);
    end else begin
      hum_clamped = hum_sum[HUM_W-1:0];
    end
  end

  always_comb begin
    result.frame_kind        = kind;
    result.crc_ok            = crc_ok;
    result.temperature_centi = '0;
    result.humidity_centi    = '0;
    case (kind)
      KIND_TEMP: begin
        if (crc_ok) begin
          result.temperature_centi = temp_full[TEMP_W-1:0];
        end
      end
      KIND_HUM: begin
        if (crc_ok) begin
          result.humidity_centi = hum_clamped;
        end
      end
      default: begin
        result.temperature_centi = '0;
      end
    endcase
  end

endmodule
`default_nettype wire
